/* src/gbn_pkg.sv */
// Shared types and constants of the go-back-N sender with retransmission timer.
// Used by every module of the block; depends on nothing.
package gbn_pkg;

  localparam int DEF_SEGMENT_BYTES   = 128;
  localparam int DEF_WINDOW_SEGMENTS = 6;
  localparam int CMD_QUEUE_DEPTH     = 4;
  localparam int RESULT_QUEUE_DEPTH  = 8;
  localparam int APB_ADDR_W          = 3;

  localparam logic REG_TRANSFER_LENGTH  = 1'b0;
  localparam logic REG_TICKS_PER_SECOND = 1'b1;

  localparam logic [15:0] TPS_RESET = 16'd1000;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_ACK,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic        seg_valid;
    logic [23:0] seg_seq;
    logic [7:0]  seg_len;
    logic        is_resend;
    logic        done_res;
    logic [24:0] rto_now;
    logic        last;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] ack_seq;
  } cmd_t;

  typedef struct packed {
    logic [23:0] transfer_length;
    logic [15:0] ticks_per_second;
  } cfg_t;

endpackage

/* src/go_back_n_sender_with_rto_top.sv */
// An input beat is queued as a command; the engine takes it in S_IDLE and runs it
// through S_EXEC and S_SETTLE to S_EMIT, which pushes its result beats into the result queue.
// An ack with an RTT sample passes S_DIFF, S_SMOOTH (once an estimate exists), S_RTO and
// S_CLAMP on the way; a timeout that finds nothing to resend first leaves the resend phase
// in S_EMIT. The single engine works on one item at a time.
// Reset: rst is synchronous; it empties both queues, clears the window state and estimator, and
// sets RTO to one second at the reset tick rate. No memory clearing pass is needed.
module go_back_n_sender_with_rto_top import gbn_pkg::*; #(
  parameter int SEGMENT_BYTES   = DEF_SEGMENT_BYTES,
  parameter int WINDOW_SEGMENTS = DEF_WINDOW_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                       cfg;
  logic                       cmd_valid;
  logic                       cmd_pop;
  cmd_t                       cmd;
  logic                       res_push;
  logic                       res_full;
  result_t                    res_item;
  logic [$bits(result_t)-1:0] res_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transfer_length  <= '0;
      cfg.ticks_per_second <= TPS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[APB_ADDR_W-1])
        REG_TRANSFER_LENGTH:  cfg.transfer_length  <= pwdata[23:0];
        REG_TICKS_PER_SECOND: cfg.ticks_per_second <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1])
      REG_TRANSFER_LENGTH:  prdata = {8'b0, cfg.transfer_length};
      REG_TICKS_PER_SECOND: prdata = {16'b0, cfg.ticks_per_second};
      default:              prdata = '0;
    endcase
  end

  gbn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  gbn_back #(
    .SEGMENT_BYTES   (SEGMENT_BYTES),
    .WINDOW_SEGMENTS (WINDOW_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  gbn_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_data),
    .empty (empty)
  );

  assign result = result_t'(res_data);

endmodule

/* src/gbn_fifo.sv */
// Small synchronous FIFO with push/full and pop/empty handshakes.
// Depends on gbn_pkg for its default width and depth.
module gbn_fifo import gbn_pkg::*; #(
  parameter int WIDTH = $bits(cmd_t),
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/gbn_front.sv */
// Front end: takes input beats, classifies the action code and queues commands.
// Depends on gbn_pkg and gbn_fifo.
module gbn_front import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  input  logic     cmd_pop,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  cmd_t                    decoded;
  logic [$bits(cmd_t)-1:0] q_data;
  logic                    q_empty;

  always_comb begin
    decoded.ack_seq = item.ack_seq;
    unique case (item.action)
      ACT_START: decoded.op = OP_START;
      ACT_ACK:   decoded.op = OP_ACK;
      ACT_TICK:  decoded.op = OP_TICK;
      default:   decoded.op = OP_NOP;
    endcase
  end

  gbn_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (decoded),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  assign cmd       = cmd_t'(q_data);
  assign cmd_valid = !q_empty;

endmodule

/* src/gbn_back.sv */
// Back end: window state, RTT estimator and segment emission, one command at a time.
// Depends on gbn_pkg; pushes result beats into the result queue.
module gbn_back import gbn_pkg::*; #(
  parameter int SEGMENT_BYTES   = DEF_SEGMENT_BYTES,
  parameter int WINDOW_SEGMENTS = DEF_WINDOW_SEGMENTS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res_item,
  input  logic    res_full
);

  localparam int KW = $clog2(WINDOW_SEGMENTS + 1);
  localparam logic [24:0] SEG  = 25'(SEGMENT_BYTES);
  localparam logic [25:0] SPAN = 26'(SEGMENT_BYTES * WINDOW_SEGMENTS);
  localparam logic [KW:0] WIN  = (KW + 1)'(WINDOW_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIFF,
    S_SMOOTH,
    S_RTO,
    S_CLAMP,
    S_SETTLE,
    S_EMIT
  } state_t;

  state_t        state;
  cmd_t          cur;
  logic [24:0]   window_base;
  logic [24:0]   next_to_send;
  logic [23:0]   sample_seq;
  logic [31:0]   sample_time;
  logic [31:0]   now_ticks;
  logic [31:0]   since_ack;
  logic [34:0]   smoothed_rtt;
  logic [34:0]   rtt_variance;
  logic [24:0]   timeout_value;
  logic          have_estimate;
  logic          running;
  logic          resend_phase;
  logic [24:0]   scan_seq;
  logic [KW-1:0] seg_count;
  logic [34:0]   rtt_meas;
  logic [34:0]   rtt_diff;
  logic [37:0]   rto_sum;

  logic [24:0] tl25;
  logic [18:0] one_sec;
  logic [24:0] max_rto;
  logic [31:0] since_inc;
  logic        timeout_hit;
  logic        ack_ok;
  logic        rtt_due;
  logic [36:0] var_x4;
  logic [36:0] rto_floor;

  logic [24:0] cur_seq;
  logic [24:0] rest;
  logic [24:0] cur_len;
  logic [24:0] nxt_seq;
  logic [25:0] limit;
  logic [KW:0] k_next;
  logic        k_room;
  logic        k_room_next;
  logic        resend_go;
  logic        send_go;
  logic        resend_more;
  logic        send_more;
  logic        emit_go;
  logic        emit_more;
  logic        empty_res;

  always_comb begin
    tl25        = {1'b0, cfg.transfer_length};
    one_sec     = {cfg.ticks_per_second, 3'b000};
    max_rto     = ({6'b0, one_sec} << 6) - ({6'b0, one_sec} << 2);
    since_inc   = (since_ack == '1) ? since_ack : since_ack + 32'd1;
    timeout_hit = running && ({since_inc, 3'b000} > {10'b0, timeout_value});
    ack_ok      = running && ({1'b0, cur.ack_seq} >= window_base);
    rtt_due     = (cur.op == OP_ACK) && ack_ok && (cur.ack_seq > sample_seq);
    var_x4      = {rtt_variance, 2'b00};
    rto_floor   = (var_x4 > {18'b0, one_sec}) ? var_x4 : {18'b0, one_sec};

    cur_seq     = resend_phase ? scan_seq : next_to_send;
    rest        = tl25 - cur_seq;
    cur_len     = (rest < SEG) ? rest : SEG;
    nxt_seq     = cur_seq + cur_len;
    limit       = {1'b0, window_base} + SPAN;
    k_next      = {1'b0, seg_count} + (KW + 1)'(1);
    k_room      = {1'b0, seg_count} < WIN;
    k_room_next = k_next < WIN;

    resend_go   = (scan_seq < next_to_send) && (scan_seq < tl25) && k_room;
    send_go     = running && ({1'b0, next_to_send} < limit) && (next_to_send < tl25) && k_room;
    resend_more = ((nxt_seq < next_to_send) && (nxt_seq < tl25) && k_room_next) ||
                  (running && ({1'b0, next_to_send} < limit) && (next_to_send < tl25) &&
                   k_room_next);
    send_more   = running && ({1'b0, nxt_seq} < limit) && (nxt_seq < tl25) && k_room_next;
    emit_go     = resend_phase ? resend_go : send_go;
    emit_more   = resend_phase ? resend_more : send_more;
    empty_res   = !resend_phase && !send_go && (seg_count == '0);
  end

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_push = (state == S_EMIT) && !res_full && (emit_go || empty_res);

  always_comb begin
    res_item.seg_valid = emit_go;
    res_item.seg_seq   = emit_go ? cur_seq[23:0] : 24'd0;
    res_item.seg_len   = emit_go ? cur_len[7:0] : 8'd0;
    res_item.is_resend = emit_go && resend_phase;
    res_item.done_res  = (window_base >= tl25);
    res_item.rto_now   = timeout_value;
    res_item.last      = !emit_go || !emit_more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_base   <= '0;
      next_to_send  <= '0;
      sample_seq    <= '0;
      sample_time   <= '0;
      now_ticks     <= '0;
      since_ack     <= '0;
      smoothed_rtt  <= '0;
      rtt_variance  <= '0;
      timeout_value <= {6'b0, TPS_RESET, 3'b000};
      have_estimate <= 1'b0;
      running       <= 1'b0;
      resend_phase  <= 1'b0;
      seg_count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          resend_phase <= (cur.op == OP_TICK) && timeout_hit;
          scan_seq     <= window_base;
          state        <= rtt_due ? S_DIFF : S_SETTLE;
          unique case (cur.op)
            OP_START: begin
              window_base   <= '0;
              next_to_send  <= '0;
              since_ack     <= '0;
              smoothed_rtt  <= '0;
              rtt_variance  <= '0;
              have_estimate <= 1'b0;
              timeout_value <= {6'b0, one_sec};
              sample_seq    <= '0;
              sample_time   <= now_ticks;
              running       <= (cfg.transfer_length != '0);
            end
            OP_ACK: begin
              if (ack_ok) begin
                window_base <= window_base + SEG;
                since_ack   <= '0;
                if (cur.ack_seq > sample_seq) begin
                  rtt_meas <= {now_ticks - sample_time, 3'b000};
                end
              end
            end
            OP_TICK: begin
              now_ticks <= now_ticks + 32'd1;
              since_ack <= timeout_hit ? '0 : since_inc;
            end
            default: begin
            end
          endcase
        end
        S_DIFF: begin
          if (!have_estimate) begin
            smoothed_rtt  <= rtt_meas;
            rtt_variance  <= rtt_meas >> 1;
            have_estimate <= 1'b1;
            state         <= S_RTO;
          end else begin
            rtt_diff <= (smoothed_rtt > rtt_meas) ? smoothed_rtt - rtt_meas
                                                  : rtt_meas - smoothed_rtt;
            state    <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          rtt_variance <= 35'((({3'b0, rtt_variance} << 1) + {3'b0, rtt_variance} +
                               {3'b0, rtt_diff}) >> 2);
          smoothed_rtt <= 35'((({4'b0, smoothed_rtt} << 3) - {4'b0, smoothed_rtt} +
                               {4'b0, rtt_meas}) >> 3);
          state        <= S_RTO;
        end
        S_RTO: begin
          rto_sum <= {3'b0, smoothed_rtt} + {1'b0, rto_floor};
          state   <= S_CLAMP;
        end
        S_CLAMP: begin
          if (rto_sum < {19'b0, one_sec}) begin
            timeout_value <= {6'b0, one_sec};
          end else if (rto_sum > {13'b0, max_rto}) begin
            timeout_value <= max_rto;
          end else begin
            timeout_value <= rto_sum[24:0];
          end
          state <= S_SETTLE;
        end
        S_SETTLE: begin
          if (window_base >= tl25) begin
            running <= 1'b0;
          end
          seg_count <= '0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (!res_full) begin
              seg_count <= k_next[KW-1:0];
              if (resend_phase) begin
                scan_seq <= nxt_seq;
              end else begin
                next_to_send <= nxt_seq;
                if (next_to_send == window_base) begin
                  sample_time <= now_ticks;
                  sample_seq  <= next_to_send[23:0];
                end
              end
              if (!emit_more) begin
                state <= S_IDLE;
              end
            end
          end else if (resend_phase) begin
            resend_phase <= 1'b0;
          end else if ((seg_count != '0) || !res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* test/tb_go_back_n_sender_with_rto_top.sv */
`timescale 1ns / 100ps
// Testbench for go_back_n_sender_with_rto_top: drives start, ack, tick and no-op beats and
// register writes, mirrors the window, timer and RTO estimator locally and checks every result beat the block returns.
// Depends on gbn_pkg and the top module only.
module tb_go_back_n_sender_with_rto_top;
  import gbn_pkg::*;

  localparam int SEG = DEF_SEGMENT_BYTES;
  localparam int WIN = DEF_WINDOW_SEGMENTS;
  localparam int RANDOM_BEATS = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [24:0] RTO_AT_RESET = 25'd8000;
  localparam logic [24:0] RTO_MAX_TPS = 25'd524280;
  localparam result_t NOTHING = '0;
  localparam result_t IDLE_AT_RESET = {1'b0, 24'd0, 8'd0, 1'b0, 1'b1, RTO_AT_RESET, 1'b1};
  localparam result_t IDLE_AT_MAX_TPS = {1'b0, 24'd0, 8'd0, 1'b0, 1'b1, RTO_MAX_TPS, 1'b1};

  typedef struct packed {
    logic        is_write;
    logic        sel;
    logic [31:0] value;
    in_item_t    beat;
    logic        typed;
    result_t     want;
  } step_t;

  localparam int STEPS = 27;
  localparam step_t DIRECTED [STEPS] = '{
    {1'b0, 1'b0, 32'd0, ACT_TICK, 24'd0, 1'b1, IDLE_AT_RESET},
    {1'b0, 1'b0, 32'd0, OP_NOP, 24'hFFFFFF, 1'b1, IDLE_AT_RESET},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'hFFFFFF, 1'b1, IDLE_AT_RESET},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b1, IDLE_AT_RESET},
    {1'b1, REG_TICKS_PER_SECOND, 32'd65535, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b1, IDLE_AT_MAX_TPS},
    {1'b1, REG_TRANSFER_LENGTH, 32'hFFFFFF, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_TICK, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd128, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd100, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'hFFFFFF, 1'b0, NOTHING},
    {1'b1, REG_TICKS_PER_SECOND, 32'd1, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b1, REG_TRANSFER_LENGTH, 32'd300, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_TICK, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_TICK, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd128, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd128, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd256, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_TICK, 24'd0, 1'b0, NOTHING},
    {1'b1, REG_TRANSFER_LENGTH, 32'd1, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_START, 24'd0, 1'b0, NOTHING},
    {1'b0, 1'b0, 32'd0, ACT_ACK, 24'd0, 1'b0, NOTHING}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic [23:0] cfg_len = '0;
  logic [15:0] cfg_tps = TPS_RESET;
  logic [24:0] base_q = '0;
  logic [24:0] next_q = '0;
  logic [23:0] timed_seq = '0;
  logic [31:0] timed_at = '0;
  logic [31:0] now_q = '0;
  logic [31:0] since_q = '0;
  logic [34:0] srtt_q = '0;
  logic [34:0] rttvar_q = '0;
  logic [24:0] rto_q = RTO_AT_RESET;
  logic        est_valid = 1'b0;
  logic        active = 1'b0;

  result_t     due_segments[$];
  result_t     head_due;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned resends_seen = 0;
  int unsigned transfers = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 23;
  int unsigned recv_idle = 58;
  bit          hold_request = 1'b0;

  go_back_n_sender_with_rto_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] seg_bytes(logic [63:0] at);
    logic [63:0] rest;
    rest = {40'd0, cfg_len} - at;
    return (rest < 64'(SEG)) ? rest : 64'(SEG);
  endfunction

  function automatic void advance_sender(in_item_t it);
    result_t     burst[$];
    result_t     seg;
    logic [63:0] at, len, rtt, sec, spread, rto, lim;
    int          i;
    sec = {45'd0, cfg_tps, 3'b000};
    case (it.action)
      ACT_START: begin
        base_q = '0;
        next_q = '0;
        since_q = '0;
        srtt_q = '0;
        rttvar_q = '0;
        est_valid = 1'b0;
        rto_q = sec[24:0];
        timed_seq = '0;
        timed_at = now_q;
        active = (cfg_len != '0);
      end
      ACT_ACK: begin
        if (active && {1'b0, it.ack_seq} >= base_q) begin
          base_q = base_q + 25'(SEG);
          since_q = '0;
          if (it.ack_seq > timed_seq) begin
            rtt = {32'd0, now_q - timed_at} << 3;
            if (!est_valid) begin
              srtt_q = rtt[34:0];
              rttvar_q = rtt[35:1];
              est_valid = 1'b1;
            end else begin
              spread = ({29'd0, srtt_q} > rtt) ? {29'd0, srtt_q} - rtt : rtt - {29'd0, srtt_q};
              rttvar_q = 35'((64'd3 * {29'd0, rttvar_q} + spread) >> 2);
              srtt_q = 35'((64'd7 * {29'd0, srtt_q} + rtt) >> 3);
            end
            spread = 64'd4 * {29'd0, rttvar_q};
            rto = {29'd0, srtt_q} + ((spread > sec) ? spread : sec);
            if (rto < sec) rto = sec;
            if (rto > 64'd60 * sec) rto = 64'd60 * sec;
            rto_q = rto[24:0];
          end
        end
      end
      ACT_TICK: begin
        now_q = now_q + 32'd1;
        if (since_q != '1) since_q = since_q + 32'd1;
        if (active && {since_q, 3'b000} > {10'd0, rto_q}) begin
          at = {39'd0, base_q};
          while (at < {39'd0, next_q} && at < {40'd0, cfg_len} && burst.size() < WIN) begin
            len = seg_bytes(at);
            seg = NOTHING;
            seg.seg_valid = 1'b1;
            seg.seg_seq = at[23:0];
            seg.seg_len = len[7:0];
            seg.is_resend = 1'b1;
            burst.push_back(seg);
            at = at + len;
          end
          since_q = '0;
        end
      end
      default: ;
    endcase
    if (base_q >= {1'b0, cfg_len}) active = 1'b0;
    if (active) begin
      lim = {39'd0, base_q} + 64'(WIN * SEG);
      while ({39'd0, next_q} < lim && next_q < {1'b0, cfg_len} && burst.size() < WIN) begin
        len = seg_bytes({39'd0, next_q});
        seg = NOTHING;
        seg.seg_valid = 1'b1;
        seg.seg_seq = next_q[23:0];
        seg.seg_len = len[7:0];
        burst.push_back(seg);
        if (next_q == base_q) begin
          timed_at = now_q;
          timed_seq = next_q[23:0];
        end
        next_q = next_q + len[24:0];
      end
    end
    if (burst.size() == 0) burst.push_back(NOTHING);
    for (i = 0; i < burst.size(); i++) begin
      seg = burst[i];
      seg.done_res = (base_q >= {1'b0, cfg_len});
      seg.rto_now = rto_q;
      seg.last = (i == burst.size() - 1);
      due_segments.push_back(seg);
    end
  endfunction

  task automatic note_mismatch(string what, result_t got, result_t want);
    errors++;
    if (errors <= 10) begin
      $display("%s at cycle %0d: got v=%0d seq=%0h len=%0d rs=%0d done=%0d rto=%0d last=%0d",
               what, cycles, got.seg_valid, got.seg_seq, got.seg_len, got.is_resend,
               got.done_res, got.rto_now, got.last);
      $display("  expected v=%0d seq=%0h len=%0d rs=%0d done=%0d rto=%0d last=%0d",
               want.seg_valid, want.seg_seq, want.seg_len, want.is_resend,
               want.done_res, want.rto_now, want.last);
    end
  endtask

  task automatic send_beat(in_item_t it);
    @(negedge clk);
    if (beats_sent == 115) begin
      send_idle = 58;
      recv_idle = 23;
    end else if (beats_sent == 230) begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_sender(it);
    beats_sent++;
  endtask

  // The block is drained before each register write, then the value is read back.
  task automatic write_register(logic sel, logic [31:0] value);
    logic [31:0] readback, want;
    @(negedge clk);
    push <= 1'b0;
    while (due_segments.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_TRANSFER_LENGTH) cfg_len = value[23:0];
    else cfg_tps = value[15:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    want = (sel == REG_TRANSFER_LENGTH) ? {8'd0, cfg_len} : {16'd0, cfg_tps};
    if (readback !== want) begin
      errors++;
      if (errors <= 10) $display("register %0d reads %0h, expected %0h", sel, readback, want);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (due_segments.size() == 0) begin
        note_mismatch("unexpected beat", result, NOTHING);
      end else begin
        head_due = due_segments.pop_front();
        if (head_due.is_resend) resends_seen++;
        if (result.seg_valid !== head_due.seg_valid || result.seg_seq !== head_due.seg_seq ||
            result.seg_len !== head_due.seg_len || result.is_resend !== head_due.is_resend ||
            result.done_res !== head_due.done_res || result.rto_now !== head_due.rto_now ||
            result.last !== head_due.last)
          note_mismatch("mismatch", result, head_due);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, due_segments.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    logic [63:0] ack;
    int unsigned target, steps, pick, span;
    int          k;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < STEPS; k++) begin
      if (DIRECTED[k].is_write) begin
        write_register(DIRECTED[k].sel, DIRECTED[k].value);
      end else begin
        send_beat(DIRECTED[k].beat);
        if (DIRECTED[k].typed) due_segments[due_segments.size() - 1] = DIRECTED[k].want;
      end
    end

    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      transfers++;
      // The long receiver stall runs on a long transfer so that the input backs up.
      pick = (transfers == 1) ? 2 : $urandom_range(0, 9);
      if (pick == 0) write_register(REG_TRANSFER_LENGTH, 32'd0);
      else if (pick == 1) write_register(REG_TRANSFER_LENGTH, $urandom_range(1, SEG));
      else if (pick == 2) write_register(REG_TRANSFER_LENGTH, 32'hFFFFFF);
      else write_register(REG_TRANSFER_LENGTH, $urandom_range(SEG + 1, 1500));
      pick = $urandom_range(0, 9);
      if (pick == 0) write_register(REG_TICKS_PER_SECOND, 32'd65535);
      else if (pick == 1) write_register(REG_TICKS_PER_SECOND, $urandom_range(4, 12));
      else write_register(REG_TICKS_PER_SECOND, $urandom_range(1, 3));
      if (transfers == 1) hold_request = 1'b1;
      it.action = ACT_START;
      it.ack_seq = 24'($urandom_range(0, 24'hFFFFFF));
      send_beat(it);
      steps = $urandom_range(12, 40);
      while (steps != 0 && beats_sent < target && (active || $urandom_range(0, 3) == 0)) begin
        pick = $urandom_range(0, 99);
        it.ack_seq = 24'($urandom_range(0, 24'hFFFFFF));
        if (pick < 45) begin
          it.action = ACT_ACK;
          span = (next_q > base_q) ? 32'(next_q - base_q) : 32'd0;
          ack = {39'd0, base_q} + 64'($urandom_range(0, span));
          if (ack > 64'hFFFFFF) ack = 64'hFFFFFF;
          it.ack_seq = ack[23:0];
        end else if (pick < 80) begin
          it.action = ACT_TICK;
        end else if (pick < 87) begin
          it.action = ACT_ACK;
          if (base_q != '0) it.ack_seq = 24'($urandom_range(0, 32'(base_q) - 32'd1));
        end else if (pick < 93) begin
          it.action = ACT_ACK;
        end else if (pick < 97) begin
          it.action = OP_NOP;
        end else begin
          it.action = ACT_START;
        end
        send_beat(it);
        steps--;
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (due_segments.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Sent %0d input beats over %0d random transfers and checked %0d result beats,",
             beats_sent, transfers, results_seen);
    $display("%0d of them timeout resends; %0d mismatches.", resends_seen, errors);
    if (errors == 0 && due_segments.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
